[sv/i2cmts_pkg.sv]
// ----------------------------------------------------------------------------
// i2cmts_pkg
// Types and constants shared by the I2C master transfer sequencer.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

   localparam int unsigned CMD_W    = 2;
   localparam int unsigned ADDR_W   = 7;
   localparam int unsigned LENGTH_W = 16;
   localparam int unsigned BYTE_W   = 8;

   typedef enum logic [1:0] {
      CMD_START_WRITE = 2'd0,
      CMD_START_READ  = 2'd1,
      CMD_STATUS      = 2'd2,
      CMD_UNUSED      = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_READY = 2'd0,
      MODE_TX    = 2'd1,
      MODE_RX    = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_TX_DONE = 2'd1,
      EV_RX_DONE = 2'd2,
      EV_STOP    = 2'd3
   } event_type;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [ADDR_W-1:0]   dev_addr;
      logic [LENGTH_W-1:0] length;
      logic                keep_bus;
      logic                flag_sb;
      logic                flag_addr;
      logic                flag_txe;
      logic                flag_btf;
      logic                flag_rxne;
      logic                flag_stopf;
      logic [BYTE_W-1:0]   rx_data;
      logic [BYTE_W-1:0]   tx_data;
   } req_type;

   typedef struct packed {
      logic              accepted;
      logic [1:0]        status;
      logic              gen_start;
      logic              gen_stop;
      logic              ack_level;
      logic              dr_write;
      logic [BYTE_W-1:0] dr_value;
      logic              tx_taken;
      logic              rx_valid;
      logic [BYTE_W-1:0] rx_value;
      logic [1:0]        event_code;
      logic              irq_enabled;
   } rsp_type;

endpackage

[sv/i2cmts_req_if.sv]
// ----------------------------------------------------------------------------
// i2cmts_req_if
// Request channel: start commands and status events, valid/ready handshake.
// ----------------------------------------------------------------------------
interface i2cmts_req_if
   import i2cmts_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [ADDR_W-1:0]   dev_addr;
   logic [LENGTH_W-1:0] length;
   logic                keep_bus;
   logic                flag_sb;
   logic                flag_addr;
   logic                flag_txe;
   logic                flag_btf;
   logic                flag_rxne;
   logic                flag_stopf;
   logic [BYTE_W-1:0]   rx_data;
   logic [BYTE_W-1:0]   tx_data;

   modport source (
      output valid, command, dev_addr, length, keep_bus, flag_sb, flag_addr,
             flag_txe, flag_btf, flag_rxne, flag_stopf, rx_data, tx_data,
      input  ready
   );

   modport sink (
      input  valid, command, dev_addr, length, keep_bus, flag_sb, flag_addr,
             flag_txe, flag_btf, flag_rxne, flag_stopf, rx_data, tx_data,
      output ready
   );
endinterface

[sv/i2cmts_rsp_if.sv]
// ----------------------------------------------------------------------------
// i2cmts_rsp_if
// Response channel: bus engine controls and completion, valid/ready handshake.
// ----------------------------------------------------------------------------
interface i2cmts_rsp_if
   import i2cmts_pkg::*;
();
   logic              valid;
   logic              ready;
   logic              accepted;
   logic [1:0]        status;
   logic              gen_start;
   logic              gen_stop;
   logic              ack_level;
   logic              dr_write;
   logic [BYTE_W-1:0] dr_value;
   logic              tx_taken;
   logic              rx_valid;
   logic [BYTE_W-1:0] rx_value;
   logic [1:0]        event_code;
   logic              irq_enabled;

   modport source (
      output valid, accepted, status, gen_start, gen_stop, ack_level, dr_write,
             dr_value, tx_taken, rx_valid, rx_value, event_code, irq_enabled,
      input  ready
   );

   modport sink (
      input  valid, accepted, status, gen_start, gen_stop, ack_level, dr_write,
             dr_value, tx_taken, rx_valid, rx_value, event_code, irq_enabled,
      output ready
   );
endinterface

[sv/i2cmts_core.sv]
// ----------------------------------------------------------------------------
// i2cmts_core
// Transfer state and single-pass step logic; one registered request per step.
// ----------------------------------------------------------------------------
module i2cmts_core
   import i2cmts_pkg::*;
#(
   parameter int unsigned LEN_WIDTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type item,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data,
   output rsp_type result
);

   localparam int unsigned XW = LEN_WIDTH + 2;

   mode_type               mode_ff, mode_in;
   logic [ADDR_W-1:0]      target_addr_ff, target_addr_in;
   logic [LEN_WIDTH-1:0]   bytes_left_ff, bytes_left_in;
   logic [LEN_WIDTH-1:0]   rx_total_ff, rx_total_in;
   logic                   hold_bus_ff, hold_bus_in;
   logic                   ack_now_ff, ack_now_in;
   logic                   irq_on_ff, irq_on_in;
   logic                   ack_enable_ff;

   logic [LEN_WIDTH-1:0]   len;
   logic [XW-1:0]          rx_total_x;
   logic [XW-1:0]          bytes_left_x;
   logic [LEN_WIDTH-1:0]   bl_dec;
   logic                   close;
   rsp_type                res;

   assign len          = LEN_WIDTH'(item.length);
   assign rx_total_x   = XW'(rx_total_ff);
   assign bytes_left_x = XW'(bytes_left_ff);

   always_comb begin
      mode_in        = mode_ff;
      target_addr_in = target_addr_ff;
      bytes_left_in  = bytes_left_ff;
      rx_total_in    = rx_total_ff;
      hold_bus_in    = hold_bus_ff;
      ack_now_in     = ack_now_ff;
      irq_on_in      = irq_on_ff;
      bl_dec         = bytes_left_ff;
      close          = 1'b0;
      res            = '0;
      if (step_en) begin
         unique case (cmd_type'(item.command))
            CMD_START_WRITE, CMD_START_READ: begin
               if (mode_ff == MODE_READY && len != '0) begin
                  res.accepted   = 1'b1;
                  res.gen_start  = 1'b1;
                  mode_in        = (item.command == CMD_START_WRITE) ? MODE_TX : MODE_RX;
                  target_addr_in = item.dev_addr;
                  bytes_left_in  = len;
                  rx_total_in    = (item.command == CMD_START_READ) ? len : '0;
                  hold_bus_in    = item.keep_bus;
                  irq_on_in      = 1'b1;
               end
            end
            CMD_STATUS: begin
               // address byte on start sent
               if (item.flag_sb) begin
                  if (mode_ff == MODE_TX) begin
                     res.dr_write = 1'b1;
                     res.dr_value = {target_addr_ff, 1'b0};
                  end else if (mode_ff == MODE_RX) begin
                     res.dr_write = 1'b1;
                     res.dr_value = {target_addr_ff, 1'b1};
                  end
               end
               // short read: nack prepared at address phase
               if (item.flag_addr && mode_ff == MODE_RX &&
                   (rx_total_x == XW'(1) || rx_total_x == XW'(2))) begin
                  ack_now_in = 1'b0;
               end
               if (item.flag_txe && mode_ff == MODE_TX && bytes_left_ff != '0) begin
                  res.dr_write  = 1'b1;
                  res.dr_value  = item.tx_data;
                  res.tx_taken  = 1'b1;
                  bytes_left_in = bytes_left_ff - LEN_WIDTH'(1);
               end
               if (item.flag_btf && mode_ff == MODE_TX && bytes_left_in == '0 &&
                   item.flag_txe) begin
                  res.gen_stop   = ~hold_bus_ff;
                  irq_on_in      = 1'b0;
                  mode_in        = MODE_READY;
                  bytes_left_in  = '0;
                  res.event_code = EV_TX_DONE;
               end
               if (item.flag_rxne && mode_ff == MODE_RX) begin
                  if (rx_total_x == XW'(1)) begin
                     res.gen_stop = ~hold_bus_ff;
                     close        = 1'b1;
                  end else begin
                     if (bytes_left_x == XW'(2)) begin
                        ack_now_in   = 1'b0;
                        res.gen_stop = ~hold_bus_ff;
                     end
                     if (bytes_left_ff != '0) begin
                        bl_dec = bytes_left_ff - LEN_WIDTH'(1);
                     end
                     bytes_left_in = bl_dec;
                     close         = (bl_dec == '0);
                  end
                  res.rx_valid = 1'b1;
                  res.rx_value = item.rx_data;
                  if (close) begin
                     irq_on_in      = 1'b0;
                     if (ack_enable_ff) begin
                        ack_now_in = 1'b1;
                     end
                     mode_in        = MODE_READY;
                     bytes_left_in  = '0;
                     rx_total_in    = '0;
                     res.event_code = EV_RX_DONE;
                  end
               end
               if (item.flag_stopf) begin
                  res.event_code = EV_STOP;
               end
            end
            default: begin
            end
         endcase
      end
      res.status      = mode_in;
      res.ack_level   = ack_now_in;
      res.irq_enabled = irq_on_in;
   end

   assign result = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_READY;
         target_addr_ff <= '0;
         bytes_left_ff  <= '0;
         rx_total_ff    <= '0;
         hold_bus_ff    <= 1'b0;
         ack_now_ff     <= 1'b1;
         irq_on_ff      <= 1'b0;
         ack_enable_ff  <= 1'b1;
      end else begin
         mode_ff        <= mode_in;
         target_addr_ff <= target_addr_in;
         bytes_left_ff  <= bytes_left_in;
         rx_total_ff    <= rx_total_in;
         hold_bus_ff    <= hold_bus_in;
         ack_now_ff     <= csr_wr_en ? csr_wr_data : ack_now_in;
         irq_on_ff      <= irq_on_in;
         if (csr_wr_en) begin
            ack_enable_ff <= csr_wr_data;
         end
      end
   end

endmodule

[sv/i2c_master_transfer_sequencer.sv]
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer
// Interrupt-driven I2C master write/read sequencing, one response per request.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries start commands (write or read, with address, length and
//   keep-bus flag) and status events (bus engine flags plus data bytes).
//   rsp_bus returns exactly one response per request: start/stop requests,
//   acknowledge level, data register write, received byte and completion.
//   csr_wr_en/csr_wr_data load the default acknowledge enable; write it only
//   while no request is in flight.
// Timing:
//   a request sits in an input register, is stepped through the transfer
//   state in one pass and lands in the response register; one request per
//   cycle is taken while the response register is empty or rsp_bus.ready is high.
// Reset:
//   mode ready, counters cleared, interrupts off, acknowledge enable set.
// Stall:
//   while rsp_bus.ready is low the response holds; one more request may be
//   taken into the input register, then req_bus.ready drops.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer
   import i2cmts_pkg::*;
#(
   parameter int unsigned LEN_WIDTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   i2cmts_req_if.sink   req_bus,
   i2cmts_rsp_if.source rsp_bus,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);

   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    out_free;
   logic    step_fire;
   logic    req_take;
   req_type req_item;
   rsp_type step_result;

   assign out_free  = ~out_valid_ff | rsp_bus.ready;
   assign step_fire = in_valid_ff & out_free;
   assign req_take  = req_bus.valid & req_bus.ready;
   assign req_bus.ready = ~in_valid_ff | out_free;

   assign req_item.command    = req_bus.command;
   assign req_item.dev_addr   = req_bus.dev_addr;
   assign req_item.length     = req_bus.length;
   assign req_item.keep_bus   = req_bus.keep_bus;
   assign req_item.flag_sb    = req_bus.flag_sb;
   assign req_item.flag_addr  = req_bus.flag_addr;
   assign req_item.flag_txe   = req_bus.flag_txe;
   assign req_item.flag_btf   = req_bus.flag_btf;
   assign req_item.flag_rxne  = req_bus.flag_rxne;
   assign req_item.flag_stopf = req_bus.flag_stopf;
   assign req_item.rx_data    = req_bus.rx_data;
   assign req_item.tx_data    = req_bus.tx_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_item;
      end
   end

   i2cmts_core #(
      .LEN_WIDTH (LEN_WIDTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (step_fire),
      .item        (in_data_ff),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .result      (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         out_data_ff <= step_result;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.accepted    = out_data_ff.accepted;
   assign rsp_bus.status      = out_data_ff.status;
   assign rsp_bus.gen_start   = out_data_ff.gen_start;
   assign rsp_bus.gen_stop    = out_data_ff.gen_stop;
   assign rsp_bus.ack_level   = out_data_ff.ack_level;
   assign rsp_bus.dr_write    = out_data_ff.dr_write;
   assign rsp_bus.dr_value    = out_data_ff.dr_value;
   assign rsp_bus.tx_taken    = out_data_ff.tx_taken;
   assign rsp_bus.rx_valid    = out_data_ff.rx_valid;
   assign rsp_bus.rx_value    = out_data_ff.rx_value;
   assign rsp_bus.event_code  = out_data_ff.event_code;
   assign rsp_bus.irq_enabled = out_data_ff.irq_enabled;

endmodule
